[rtl/slf_pkg.sv]
// Shared types and constants for the substring line finder.
// Holds request/response payload structs, mode codes and cell control.
// No dependencies.
package slf_pkg;

    // Width of the offset and line counters.
    localparam int CNT_W = 20;
    // Default number of pattern cells.
    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Request modes
    typedef enum logic [1:0] {
        MODE_PATTERN  = 2'd0,
        MODE_TEXT     = 2'd1,
        MODE_NEW_TEXT = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] char_value;
        logic [4:0] pattern_index;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0] match_line;
        logic [CNT_W-1:0] match_offset;
    } rsp_t;

    // Per-cycle controls broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // move text bytes one cell down the chain
        logic rotate;  // rotate pattern bytes one cell around the ring
    } cell_ctrl_t;

endpackage

[rtl/slf_cell.sv]
// One cell of the matcher chain: a text window byte and a pattern byte.
// Compares its pattern byte with the text byte entering it.
// Depends on slf_pkg.
module slf_cell (
    input  logic                clk,
    input  slf_pkg::cell_ctrl_t ctrl,
    input  logic                wr_en,
    input  logic [7:0]          wr_data,
    input  logic [7:0]          win_in,
    input  logic [7:0]          pat_in,
    output logic [7:0]          win_out,
    output logic [7:0]          pat_out,
    output logic                eq
);
    import slf_pkg::*;

    logic [7:0] win_reg;
    logic [7:0] win_next;
    logic [7:0] pat_reg;
    logic [7:0] pat_next;

    // Shift the text byte in from the neighbor
    always_comb
    begin
        win_next = ctrl.shift ? win_in : win_reg;
    end

    // Write a pattern byte, or rotate it in from the neighbor
    always_comb
    begin
        if (wr_en)
        begin
            pat_next = wr_data;
        end
        else if (ctrl.rotate)
        begin
            pat_next = pat_in;
        end
        else
        begin
            pat_next = pat_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        pat_reg <= pat_next;
    end

    // Compare against the byte that lands here on this shift
    assign eq      = (pat_reg == win_in);
    assign win_out = win_reg;
    assign pat_out = pat_reg;

endmodule

[rtl/slf_rsp_buf.sv]
// Response output register with one skid entry.
// Lets a new request in while a finished response waits downstream.
// Depends on slf_pkg.
module slf_rsp_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  slf_pkg::rsp_t res_data,
    output logic          full,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output slf_pkg::rsp_t rsp_data
);
    import slf_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    rsp_t out_data_reg;
    rsp_t out_data_next;
    rsp_t skid_data_reg;
    rsp_t skid_data_next;
    logic pop;

    assign pop = out_valid_reg & rsp_ready;

    // Drain the skid entry first, else place a new response
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = res_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

[rtl/substring_line_finder.sv]
// Streaming exact substring matcher with line tracking, built as a chain of
// PATTERN_MAX cells that each hold one text window byte and one pattern byte.
// Depends on slf_pkg, slf_cell and slf_rsp_buf.
//
// Load pattern bytes with mode-0 requests, set pattern_length through cfg_we,
// then stream text one byte per request (mode 1); mode 2 restarts offset and
// line counting. Every occurrence (overlaps included) yields one response
// with the line and zero-based offset of its first byte. The pattern bytes
// sit in a ring that is rotated so each cell faces the right window byte for
// the current length, and the newline count inside the pattern is kept in a
// register. Both are rebuilt by a busy pass around the ring of PATTERN_MAX
// recount steps, then up to PATTERN_MAX-1 alignment steps, then leaving the
// pass. A pattern_length write starts this pass, and so does a pattern write
// that lands inside the active part of the pattern (past its first byte);
// other pattern writes start no pass. A length write during a pass restarts
// the pass. req_ready is low during that pass and while both response slots
// are full.
module substring_line_finder #(
    parameter int PATTERN_MAX = slf_pkg::PATTERN_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  slf_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output slf_pkg::rsp_t rsp_data,
    input  logic          cfg_we,
    input  logic [5:0]    cfg_wdata
);
    import slf_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int DW = ((AW > 5) ? AW : 5) + 1;

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_BUSY  = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [5:0]       pattern_length_reg;
    logic [5:0]       pattern_length_next;
    logic [AW-1:0]    align_reg;
    logic [AW-1:0]    align_next;
    logic [LW-1:0]    step_reg;
    logic [LW-1:0]    step_next;
    logic [LW-1:0]    nl_cnt_reg;
    logic [LW-1:0]    nl_cnt_next;
    logic [CNT_W-1:0] char_count_reg;
    logic [CNT_W-1:0] char_count_next;
    logic [CNT_W-1:0] line_count_reg;
    logic [CNT_W-1:0] line_count_next;

    logic             accept;
    logic             is_text;
    logic             is_pattern;
    logic             is_new_text;
    logic             skid_full;
    cell_ctrl_t       ctrl;
    logic             rotate_en;
    logic [LW-1:0]    len_eff;
    logic [AW-1:0]    target_align;
    logic             aligned;
    logic             count_done;
    logic             tap_counts;
    logic             idx_ok;
    logic             idx_in_use;
    logic [DW-1:0]    addr_diff;
    logic [AW-1:0]    wr_addr;
    logic [PATTERN_MAX-1:0] active;
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] wr_en;
    logic [7:0]       win_q [PATTERN_MAX];
    logic [7:0]       pat_q [PATTERN_MAX];
    logic             hit;
    logic             res_valid;
    rsp_t             res_data;

    assign accept = req_valid & req_ready;
    assign req_ready = (state_reg == ST_READY) & ~skid_full;

    // Decode the request mode
    always_comb
    begin
        is_text     = 1'b0;
        is_pattern  = 1'b0;
        is_new_text = 1'b0;
        unique case (req_data.mode)
            MODE_PATTERN:  is_pattern  = 1'b1;
            MODE_TEXT:     is_text     = 1'b1;
            MODE_NEW_TEXT: is_new_text = 1'b1;
            default:       is_text     = 1'b0;
        endcase
    end

    // Clamp the length to the chain size and derive the ring alignment
    always_comb
    begin
        if (32'(pattern_length_reg) > 32'(PATTERN_MAX))
        begin
            len_eff = LW'(PATTERN_MAX);
        end
        else
        begin
            len_eff = LW'(pattern_length_reg);
        end
        target_align = (len_eff == '0) ? '0 : AW'(len_eff - LW'(1));
    end

    assign aligned    = (align_reg == target_align);
    assign count_done = (step_reg == LW'(PATTERN_MAX));
    // Cell 0 holds pattern byte number align_reg; count it if past the first
    assign tap_counts = (align_reg != '0) && (LW'(align_reg) < len_eff)
                        && (pat_q[0] == NEWLINE_BYTE);

    // Map a pattern index onto the cell that holds it at this alignment
    always_comb
    begin
        idx_ok     = 32'(req_data.pattern_index) < 32'(PATTERN_MAX);
        idx_in_use = (req_data.pattern_index != '0)
                     && (32'(req_data.pattern_index) < 32'(len_eff));
        addr_diff  = DW'(align_reg) - DW'(req_data.pattern_index);
        if (addr_diff[DW-1])
        begin
            addr_diff = addr_diff + DW'(PATTERN_MAX);
        end
        wr_addr = AW'(addr_diff);
    end

    // Decode the pattern write and the active cell range
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            wr_en[i]  = accept && is_pattern && idx_ok && (wr_addr == AW'(i));
            active[i] = LW'(i) < len_eff;
        end
    end

    // Sequence the alignment and newline recount pass
    always_comb
    begin
        state_next          = state_reg;
        pattern_length_next = pattern_length_reg;
        align_next          = align_reg;
        step_next           = step_reg;
        nl_cnt_next         = nl_cnt_reg;
        rotate_en           = 1'b0;
        unique case (state_reg)
            ST_READY:
            begin
                if (cfg_we)
                begin
                    pattern_length_next = cfg_wdata;
                    state_next          = ST_BUSY;
                    step_next           = '0;
                    nl_cnt_next         = '0;
                end
                else if (accept && is_pattern && idx_ok && idx_in_use)
                begin
                    state_next  = ST_BUSY;
                    step_next   = '0;
                    nl_cnt_next = '0;
                end
            end
            ST_BUSY:
            begin
                if (cfg_we)
                begin
                    // Restart the pass for the new length
                    pattern_length_next = cfg_wdata;
                    step_next           = '0;
                    nl_cnt_next         = '0;
                end
                else if (!count_done)
                begin
                    rotate_en = 1'b1;
                    step_next = step_reg + LW'(1);
                    if (tap_counts)
                    begin
                        nl_cnt_next = nl_cnt_reg + LW'(1);
                    end
                end
                else if (!aligned)
                begin
                    rotate_en = 1'b1;
                end
                else
                begin
                    state_next = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
        if (rotate_en)
        begin
            align_next = (align_reg == AW'(PATTERN_MAX - 1)) ? '0 : align_reg + AW'(1);
        end
    end

    assign ctrl = '{shift: accept & is_text, rotate: rotate_en};

    // Advance the offset and line counters, saturating at all ones
    always_comb
    begin
        char_count_next = char_count_reg;
        line_count_next = line_count_reg;
        if (accept && is_new_text)
        begin
            char_count_next = '0;
            line_count_next = CNT_W'(1);
        end
        else if (ctrl.shift)
        begin
            if (char_count_reg != CNT_MAX)
            begin
                char_count_next = char_count_reg + CNT_W'(1);
            end
            if ((req_data.char_value == NEWLINE_BYTE) && (line_count_reg != CNT_MAX))
            begin
                line_count_next = line_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_READY;
            pattern_length_reg <= '0;
            align_reg          <= '0;
            step_reg           <= '0;
            nl_cnt_reg         <= '0;
            char_count_reg     <= '0;
            line_count_reg     <= CNT_W'(1);
        end
        else
        begin
            state_reg          <= state_next;
            pattern_length_reg <= pattern_length_next;
            align_reg          <= align_next;
            step_reg           <= step_next;
            nl_cnt_reg         <= nl_cnt_next;
            char_count_reg     <= char_count_next;
            line_count_reg     <= line_count_next;
        end
    end

    // Chain of cells: text shifts up from cell 0, pattern rotates as a ring
    for (genvar g = 0; g < PATTERN_MAX; g++)
    begin : g_cell
        logic [7:0] win_in;
        logic [7:0] pat_in;
        if (g == 0)
        begin : g_head
            assign win_in = req_data.char_value;
            assign pat_in = pat_q[PATTERN_MAX-1];
        end
        else
        begin : g_body
            assign win_in = win_q[g-1];
            assign pat_in = pat_q[g-1];
        end
        slf_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .wr_en   (wr_en[g]),
            .wr_data (req_data.char_value),
            .win_in  (win_in),
            .pat_in  (pat_in),
            .win_out (win_q[g]),
            .pat_out (pat_q[g]),
            .eq      (eq[g])
        );
    end

    // Combine the cell compares and form the response fields
    always_comb
    begin
        hit = (len_eff != '0) && (char_count_next >= CNT_W'(len_eff))
              && (&(eq | ~active));
        if (line_count_next == CNT_MAX)
        begin
            res_data.match_line = CNT_MAX;
        end
        else if (line_count_next > CNT_W'(nl_cnt_reg))
        begin
            res_data.match_line = line_count_next - CNT_W'(nl_cnt_reg);
        end
        else
        begin
            res_data.match_line = CNT_W'(1);
        end
        if (char_count_next == CNT_MAX)
        begin
            res_data.match_offset = CNT_MAX;
        end
        else
        begin
            res_data.match_offset = char_count_next - CNT_W'(len_eff);
        end
    end

    assign res_valid = ctrl.shift & hit;

    slf_rsp_buf u_rsp_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .full      (skid_full),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

`ifndef SYNTHESIS
    // A length write always starts a recount pass
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == ST_BUSY))
        else $error("length write did not start a recount pass");

    // The ring faces the window correctly whenever requests are taken
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READY) |-> aligned)
        else $error("pattern ring misaligned while ready");

    // Newlines counted exclude the first pattern byte
    a_nl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READY) |-> ((nl_cnt_reg == '0) || (nl_cnt_reg < len_eff)))
        else $error("newline count exceeds pattern length");

    // A full skid entry must hold off new requests
    a_skid_stall: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full |-> !req_ready)
        else $error("request taken with both response slots full");
`endif

endmodule

[dv/tb_substring_line_finder.sv]
`timescale 1ns / 100ps
// Self-checking bench for substring_line_finder: random requests with idle gaps,
// an in-bench predictor of hits (line, offset) and an in-order response check.
// Depends on slf_pkg and the substring_line_finder RTL.
module tb_substring_line_finder;
    import slf_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PAT_CELLS = 32;
    localparam int SETTLE_CYCLES = 80;     // covers the longest ring rebuild pass
    localparam int LONG_STALL = 300;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_LIMIT = 10000;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        req_t       req;
        logic [3:0] gap;
    } pending_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    req_t       req_data = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    rsp_t       rsp_data;
    logic       cfg_we = 1'b0;
    logic [5:0] cfg_wdata = '0;

    // Request queue and expected hits
    pending_t pending_reqs[$];
    rsp_t     expected_hits[$];
    pending_t next_req;
    logic [3:0] idle_cnt;

    // Predictor state
    logic [7:0]       pat_bytes [0:PAT_CELLS-1];
    logic [7:0]       recent_bytes [0:PAT_CELLS-1];
    logic [CNT_W-1:0] line_cnt;
    logic [CNT_W-1:0] offset_cnt;
    logic [5:0]       active_len = '0;

    // Stimulus-side copy of the pattern, used to build occurrences
    logic [7:0] gen_pat [0:PAT_CELLS-1];
    bit         burst = 1'b0;
    logic       quiet_rsp = 1'b0;
    logic       pressure_on = 1'b0;
    int         counted = 0;

    // Receiver state
    logic [3:0] rsp_wait;
    int         rsp_pause;
    int         stall_left;
    logic       stall_done;
    int         mismatch_cnt = 0;

    substring_line_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (mismatch_cnt < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic void restart_text();
        int i;
        for (i = 0; i < PAT_CELLS; i++)
            recent_bytes[i] = 8'h00;
        line_cnt = CNT_W'(1);
        offset_cnt = '0;
    endfunction

    // Advance the predictor by one accepted request; queue the hit it causes
    function automatic void track_request(input req_t r);
        int   i;
        int   eff_len;
        int   inner_nl;
        bit   hit;
        rsp_t hit_rsp;
        case (r.mode)
            MODE_PATTERN: pat_bytes[r.pattern_index] = r.char_value;
            MODE_NEW_TEXT: restart_text();
            MODE_TEXT:
            begin
                for (i = PAT_CELLS - 1; i > 0; i--)
                    recent_bytes[i] = recent_bytes[i-1];
                recent_bytes[0] = r.char_value;
                if (offset_cnt != CNT_MAX)
                    offset_cnt = offset_cnt + 1'b1;
                if (r.char_value == NEWLINE_BYTE && line_cnt != CNT_MAX)
                    line_cnt = line_cnt + 1'b1;
                eff_len = (active_len > PAT_CELLS) ? PAT_CELLS : int'(active_len);
                if (eff_len != 0 && offset_cnt >= eff_len)
                begin
                    hit = 1'b1;
                    inner_nl = 0;
                    for (i = 0; i < eff_len && hit; i++)
                    begin
                        if (pat_bytes[i] != recent_bytes[eff_len-1-i])
                            hit = 1'b0;
                        else if (i > 0 && pat_bytes[i] == NEWLINE_BYTE)
                            inner_nl++;
                    end
                    if (hit)
                    begin
                        if (line_cnt == CNT_MAX)
                            hit_rsp.match_line = CNT_MAX;
                        else if (line_cnt > inner_nl)
                            hit_rsp.match_line = line_cnt - CNT_W'(inner_nl);
                        else
                            hit_rsp.match_line = CNT_W'(1);
                        if (offset_cnt == CNT_MAX)
                            hit_rsp.match_offset = CNT_MAX;
                        else
                            hit_rsp.match_offset = offset_cnt - CNT_W'(eff_len);
                        expected_hits.push_back(hit_rsp);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_hit(input rsp_t got);
        rsp_t want;
        if (expected_hits.size() == 0)
            flag_mismatch($sformatf("unexpected hit line %0d offset %0d",
                                    got.match_line, got.match_offset));
        else
        begin
            want = expected_hits.pop_front();
            if (got.match_line != want.match_line)
                flag_mismatch($sformatf("match line got %0d want %0d (offset %0d)",
                                        got.match_line, want.match_line,
                                        want.match_offset));
            if (got.match_offset != want.match_offset)
                flag_mismatch($sformatf("match offset got %0d want %0d",
                                        got.match_offset, want.match_offset));
        end
    endtask

    // Present queued requests, honoring each one's idle gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            idle_cnt <= '0;
            restart_text();
        end
        else
        begin
            if (req_valid && req_ready)
                track_request(req_data);
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() != 0 && idle_cnt >= pending_reqs[0].gap)
                begin
                    next_req = pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    req_data <= next_req.req;
                    idle_cnt <= '0;
                end
                else
                begin
                    req_valid <= 1'b0;
                    if (idle_cnt != 4'd15)
                        idle_cnt <= idle_cnt + 1'b1;
                end
            end
        end
    end

    // Hold off responses once for a long stretch so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (pressure_on && !stall_done)
        begin
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Accept and check responses, drawing a pause after each one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_wait <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            check_hit(rsp_data);
            rsp_pause = quiet_rsp ? 0 : $urandom_range(0, 11);
            rsp_wait <= 4'(rsp_pause);
            rsp_ready <= (rsp_pause == 0) && (stall_left == 0);
        end
        else if (rsp_wait != 0)
        begin
            rsp_wait <= rsp_wait - 1'b1;
            rsp_ready <= (rsp_wait == 4'd1) && (stall_left == 0);
        end
        else
            rsp_ready <= (stall_left == 0);
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 6))
            0: return NEWLINE_BYTE;
            1: return 8'h00;
            2: return 8'hFF;
            3, 4: return 8'h61 + 8'($urandom_range(0, 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_req(input mode_t m, input logic [7:0] c, input logic [4:0] idx);
        pending_t p;
        p.req.mode = m;
        p.req.char_value = c;
        p.req.pattern_index = idx;
        if (burst || $urandom_range(0, 3) == 0)
            p.gap = '0;
        else
            p.gap = 4'($urandom_range(0, 11));
        pending_reqs.push_back(p);
        if (m != mode_t'(MODE_UNUSED))
            counted++;
    endtask

    task automatic push_text(input logic [7:0] c);
        push_req(MODE_TEXT, c, 5'($urandom_range(0, 31)));
    endtask

    task automatic push_pattern(input logic [4:0] idx, input logic [7:0] c);
        push_req(MODE_PATTERN, c, idx);
        gen_pat[idx] = c;
    endtask

    // Drain everything, then let any ring rebuild finish
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [5:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_len = v;
    endtask

    initial
    begin
        int         phase;
        int         k;
        int         n;
        int         roll;
        int         reps;
        int         bad;
        int         eff;
        int         target;
        logic [5:0] len_cfg;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pattern: text never hits; the unused mode does nothing
        push_req(mode_t'(MODE_UNUSED), 8'hFF, 5'd31);
        push_text(8'h61);
        push_text(8'hFF);
        push_text(NEWLINE_BYTE);
        push_pattern(5'd0, NEWLINE_BYTE);
        push_pattern(5'd1, 8'h00);
        push_pattern(5'd2, NEWLINE_BYTE);
        push_pattern(5'd31, 8'hFF);
        wait_idle();
        write_length(6'd3);

        // Overlapping hits that start on newlines, zero bytes inside
        push_req(MODE_NEW_TEXT, 8'h00, 5'd0);
        push_text(NEWLINE_BYTE);
        push_text(8'h00);
        push_text(NEWLINE_BYTE);
        push_text(8'h00);
        push_text(NEWLINE_BYTE);
        // Too short to hit after a restart
        push_req(MODE_NEW_TEXT, 8'hFF, 5'd31);
        push_text(NEWLINE_BYTE);
        push_text(8'h00);
        wait_idle();
        write_length(6'd1);

        // Single newline pattern, then rewrite the pattern mid-text
        push_text(NEWLINE_BYTE);
        push_text(8'h41);
        push_text(NEWLINE_BYTE);
        push_pattern(5'd0, 8'h41);
        push_text(8'h41);

        // Random phases: fresh pattern and length, then mostly occurrences
        counted = 0;
        for (phase = 0; counted < RANDOM_ITEMS; phase++)
        begin
            case (phase)
                0: len_cfg = 6'd1;
                1: len_cfg = 6'd63;
                2: len_cfg = 6'd0;
                3: len_cfg = 6'd32;
                default:
                    case ($urandom_range(0, 9))
                        0: len_cfg = 6'd0;
                        1: len_cfg = 6'($urandom_range(32, 63));
                        2: len_cfg = 6'd32;
                        default: len_cfg = 6'($urandom_range(1, 8));
                    endcase
            endcase
            eff = (len_cfg > PAT_CELLS) ? PAT_CELLS : int'(len_cfg);
            burst = (phase == 0) || ($urandom_range(0, 3) == 0);
            quiet_rsp <= ($urandom_range(0, 3) == 0);
            for (k = 0; k < eff; k++)
                push_pattern(5'(k), pick_byte());
            wait_idle();
            write_length(len_cfg);
            if (phase == 0)
                pressure_on <= 1'b1;
            push_req(MODE_NEW_TEXT, pick_byte(), 5'($urandom_range(0, 31)));
            target = counted + 120;
            while (counted < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60 && eff != 0)
                begin
                    // Occurrence after a short prefix; some broken, some doubled
                    repeat ($urandom_range(0, 2)) push_text(pick_byte());
                    bad = (roll < 12) ? $urandom_range(0, eff - 1) : PAT_CELLS;
                    reps = (roll >= 50) ? 2 : 1;
                    repeat (reps)
                        for (k = 0; k < eff; k++)
                            push_text((k == bad) ? gen_pat[k] ^ 8'h01 : gen_pat[k]);
                end
                else if (roll < 88)
                    push_text(pick_byte());
                else if (roll < 92)
                    push_req(MODE_NEW_TEXT, pick_byte(), 5'($urandom_range(0, 31)));
                else if (roll < 97)
                    push_pattern(5'($urandom_range(0, 31)), pick_byte());
                else
                    push_req(mode_t'(MODE_UNUSED), 8'($urandom_range(0, 255)),
                             5'($urandom_range(0, 31)));
                while (pending_reqs.size() > 64)
                    @(posedge clk);
            end
        end

        // Drain, allow for trailing latency, then judge
        n = 0;
        while ((pending_reqs.size() != 0 || req_valid || expected_hits.size() != 0)
               && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_reqs.size() != 0 || req_valid)
            flag_mismatch($sformatf("%0d requests never accepted", pending_reqs.size()));
        if (expected_hits.size() != 0)
            flag_mismatch($sformatf("%0d expected hits never came out", expected_hits.size()));
        if (mismatch_cnt == 0)
            $display("PASS substring_line_finder");
        else
            $display("FAIL substring_line_finder");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #TIMEOUT_NS;
        $display("FAIL substring_line_finder");
        $finish;
    end

endmodule

[sim.f]
rtl/slf_pkg.sv
rtl/slf_cell.sv
rtl/slf_rsp_buf.sv
rtl/substring_line_finder.sv
dv/tb_substring_line_finder.sv
